/* rtl/obj_face_index_parser_core_defines.svh */
// ----------------------------------------------------------------------------
// Face corner parser assertion macros
// Shared concurrent assertion shorthands, clocked on clk with a reset guard.
// ----------------------------------------------------------------------------
`ifndef OBJ_FACE_INDEX_PARSER_CORE_DEFINES_SVH
`define OBJ_FACE_INDEX_PARSER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OFIP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ofip: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OFIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ofip: next-cycle check failed");

`endif

/* rtl/ofip_pkg.sv */
// ----------------------------------------------------------------------------
// Face corner parser package
// Register indexes, parser state codes and character classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ofip_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_VERTEX_COUNT   = 2'd0;
  localparam logic [1:0] CFG_TEXCOORD_COUNT = 2'd1;
  localparam logic [1:0] CFG_NORMAL_COUNT   = 2'd2;

  // Which field of the corner token is being read.
  localparam logic [1:0] PH_VERT = 2'd0;
  localparam logic [1:0] PH_TEX  = 2'd1;
  localparam logic [1:0] PH_NORM = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Progress within one number.
  localparam logic [1:0] ST_START  = 2'd0;
  localparam logic [1:0] ST_SPACE  = 2'd1;
  localparam logic [1:0] ST_SIGN   = 2'd2;
  localparam logic [1:0] ST_DIGITS = 2'd3;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic digit;
    logic space;
    logic sign;
    logic minus;
    logic slash;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t k;
    k.digit = (c >= CH_ZERO) && (c <= CH_NINE);
    k.space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    k.minus = (c == CH_MINUS);
    k.sign  = (c == CH_PLUS) || k.minus;
    k.slash = (c == CH_SLASH);
    return k;
  endfunction

endpackage

/* rtl/ofip_char_if.sv */
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one token character and its end flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ofip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       token_end;

  modport source (output valid, output text_char, output token_end, input ready);
  modport sink   (input valid, input text_char, input token_end, output ready);
endinterface

/* rtl/ofip_corner_if.sv */
// ----------------------------------------------------------------------------
// Corner result channel
// Valid/ready channel carrying one resolved face corner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ofip_corner_if #(
  parameter int INDEX_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic                   corner_valid;
  logic [INDEX_WIDTH-1:0] vertex_index;
  logic [INDEX_WIDTH-1:0] texcoord_index;
  logic [INDEX_WIDTH-1:0] normal_index;

  modport source (output valid, output corner_valid, output vertex_index,
                  output texcoord_index, output normal_index, input ready);
  modport sink   (input valid, input corner_valid, input vertex_index,
                  input texcoord_index, input normal_index, output ready);
endinterface

/* rtl/obj_face_index_parser_core.sv */
// Usage: characters of one OBJ face-corner token ("v", "v/vt", "v//vn" or
// "v/vt/vn") enter on in_chan, one transaction per character, with token_end
// set on the final character. Each number reads like strtol: leading
// whitespace, an optional sign, then decimal digits. On the final character
// one corner transaction leaves on out_chan; other characters produce none.
// The list sizes used to resolve negative and out-of-range indexes are
// written through cfg_we/cfg_index/cfg_wdata (vertex, texcoord, normal).
// Throughput is one character per cycle while in_chan.ready is high, with
// no bubbles between tokens. The scanner state and the raw field values are
// registered on the final character, then the add-and-compare resolver
// feeds the output register. The two registered stages let a new character
// be taken while a finished corner still waits on out_chan.
// When out_chan is stalled the output register and the hand-off register
// hold, and in_chan.ready falls only once both are full.
// Synchronous reset (rst_n low) clears the scanner, empties both stages and
// sets all three list sizes to zero.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OBJ face corner index parser, top level
// Configuration registers, character scanner and index resolver.
// ----------------------------------------------------------------------------

`include "obj_face_index_parser_core_defines.svh"

module obj_face_index_parser_core #(
  parameter int INDEX_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ofip_char_if.sink              in_chan,
  ofip_corner_if.source          out_chan,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [INDEX_WIDTH-1:0] cfg_wdata
);
  import ofip_pkg::*;

  logic [INDEX_WIDTH-1:0] vcount_r, tcount_r, ncount_r;

  logic                          hand_valid;
  logic                          hand_ready;
  logic                          vert_seen;
  logic signed [INDEX_WIDTH+1:0] vert_raw, tex_raw, norm_raw;

  // List sizes; an index beyond the three registers is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      tcount_r <= '0;
      ncount_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT:   vcount_r <= cfg_wdata;
        CFG_TEXCOORD_COUNT: tcount_r <= cfg_wdata;
        CFG_NORMAL_COUNT:   ncount_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ofip_parse #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .hand_valid (hand_valid),
    .hand_ready (hand_ready),
    .vert_seen  (vert_seen),
    .vert_raw   (vert_raw),
    .tex_raw    (tex_raw),
    .norm_raw   (norm_raw)
  );

  ofip_resolve #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_resolve (
    .clk            (clk),
    .rst_n          (rst_n),
    .hand_valid     (hand_valid),
    .hand_ready     (hand_ready),
    .vert_seen      (vert_seen),
    .vert_raw       (vert_raw),
    .tex_raw        (tex_raw),
    .norm_raw       (norm_raw),
    .vertex_count   (vcount_r),
    .texcoord_count (tcount_r),
    .normal_count   (ncount_r),
    .out_chan       (out_chan)
  );

  // A final character always leaves a pending corner in the hand-off stage.
  `OFIP_ASSERT_NEXT(a_last_hands_off, in_chan.valid && in_chan.ready && in_chan.token_end, hand_valid)
  // A usable corner names a vertex inside the current list.
  `OFIP_ASSERT_SAME(a_vertex_in_range, out_chan.valid && out_chan.corner_valid, (out_chan.vertex_index != '0) && (out_chan.vertex_index <= vcount_r))
  // Texture and normal indexes never exceed their list sizes.
  `OFIP_ASSERT_SAME(a_aux_in_range, out_chan.valid, (out_chan.texcoord_index <= tcount_r) && (out_chan.normal_index <= ncount_r))
  // An unusable corner carries all-zero indexes.
  `OFIP_ASSERT_SAME(a_invalid_zero, out_chan.valid && !out_chan.corner_valid, (out_chan.vertex_index == '0) && (out_chan.texcoord_index == '0) && (out_chan.normal_index == '0))

endmodule

/* rtl/ofip_parse.sv */
// ----------------------------------------------------------------------------
// Face corner token parser
// Per-character field scanner; hands raw signed field values on token end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ofip_parse #(
  parameter int INDEX_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ofip_char_if.sink              in_chan,
  output logic                   hand_valid,
  input  logic                   hand_ready,
  output logic                   vert_seen,
  output logic signed [INDEX_WIDTH+1:0] vert_raw,
  output logic signed [INDEX_WIDTH+1:0] tex_raw,
  output logic signed [INDEX_WIDTH+1:0] norm_raw
);
  import ofip_pkg::*;

  localparam int AW = INDEX_WIDTH + 1;  // magnitude width, saturates at all ones
  localparam int VW = INDEX_WIDTH + 2;  // signed value width

  logic [1:0]           phase_r, phase_nxt;
  logic [1:0]           stage_r, stage_nxt;
  logic                 neg_r, neg_nxt;
  logic [AW-1:0]        acc_r, acc_nxt;
  logic signed [VW-1:0] vval_r, vval_nxt;
  logic signed [VW-1:0] tval_r, tval_nxt;
  logic                 seen_r, seen_nxt;

  logic                 hvalid_r;
  logic                 hseen_r;
  logic signed [VW-1:0] hvert_r, htex_r, hnorm_r;

  logic                 in_acc;
  char_class_t          cls;
  logic [3:0]           dig;
  logic [AW+3:0]        prod;
  logic [AW-1:0]        acc_sat;
  logic signed [VW-1:0] cur_val, nxt_val;

  assign in_chan.ready = !hvalid_r || hand_ready;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign cls           = classify(in_chan.text_char);
  assign dig           = in_chan.text_char[3:0];

  // acc * 10 + digit, as two shifted copies, clamped to the saturation cap.
  assign prod    = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {{AW{1'b0}}, dig};
  assign acc_sat = (|prod[AW+3:AW]) ? {AW{1'b1}} : prod[AW-1:0];

  assign cur_val = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
  assign nxt_val = neg_nxt ? -$signed({1'b0, acc_nxt}) : $signed({1'b0, acc_nxt});

  always_comb begin
    phase_nxt = phase_r;
    stage_nxt = stage_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    vval_nxt  = vval_r;
    tval_nxt  = tval_r;
    seen_nxt  = seen_r;
    if (in_acc && (phase_r != PH_DONE)) begin
      unique case (stage_r)
        ST_START, ST_SPACE: begin
          priority if ((phase_r == PH_TEX) && (stage_r == ST_START) && cls.slash) begin
            phase_nxt = PH_NORM;
            stage_nxt = ST_START;
            neg_nxt   = 1'b0;
            acc_nxt   = '0;
          end else if (cls.space) begin
            stage_nxt = ST_SPACE;
          end else if (cls.sign) begin
            stage_nxt = ST_SIGN;
            neg_nxt   = cls.minus;
          end else if (cls.digit) begin
            stage_nxt = ST_DIGITS;
            acc_nxt   = {{(AW-4){1'b0}}, dig};
          end else begin
            phase_nxt = PH_DONE;
            stage_nxt = ST_START;
            neg_nxt   = 1'b0;
            acc_nxt   = '0;
          end
        end
        ST_SIGN: begin
          if (cls.digit) begin
            stage_nxt = ST_DIGITS;
            acc_nxt   = {{(AW-4){1'b0}}, dig};
          end else begin
            phase_nxt = PH_DONE;
            stage_nxt = ST_START;
            neg_nxt   = 1'b0;
            acc_nxt   = '0;
          end
        end
        ST_DIGITS: begin
          if (cls.digit) begin
            acc_nxt = acc_sat;
          end else begin
            stage_nxt = ST_START;
            if (phase_r == PH_VERT) begin
              vval_nxt  = cur_val;
              seen_nxt  = 1'b1;
              phase_nxt = cls.slash ? PH_TEX : PH_DONE;
              neg_nxt   = 1'b0;
              acc_nxt   = '0;
            end else if (phase_r == PH_TEX) begin
              tval_nxt  = cur_val;
              phase_nxt = cls.slash ? PH_NORM : PH_DONE;
              neg_nxt   = 1'b0;
              acc_nxt   = '0;
            end else begin
              // The normal value stays in the accumulator until the token ends.
              phase_nxt = PH_DONE;
            end
          end
        end
        default: begin
          stage_nxt = ST_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_VERT;
      stage_r  <= ST_START;
      neg_r    <= 1'b0;
      acc_r    <= '0;
      vval_r   <= '0;
      tval_r   <= '0;
      seen_r   <= 1'b0;
      hvalid_r <= 1'b0;
    end else begin
      if (in_acc && in_chan.token_end) begin
        phase_r  <= PH_VERT;
        stage_r  <= ST_START;
        neg_r    <= 1'b0;
        acc_r    <= '0;
        vval_r   <= '0;
        tval_r   <= '0;
        seen_r   <= 1'b0;
        hvalid_r <= 1'b1;
      end else begin
        phase_r <= phase_nxt;
        stage_r <= stage_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
        vval_r  <= vval_nxt;
        tval_r  <= tval_nxt;
        seen_r  <= seen_nxt;
        if (hand_ready) begin
          hvalid_r <= 1'b0;
        end
      end
    end
  end

  // Raw field values of the finished token, taken from the updated state.
  always_ff @(posedge clk) begin
    if (in_acc && in_chan.token_end) begin
      if ((phase_nxt == PH_VERT) && (stage_nxt == ST_DIGITS)) begin
        hvert_r <= nxt_val;
        hseen_r <= 1'b1;
      end else begin
        hvert_r <= vval_nxt;
        hseen_r <= seen_nxt;
      end
      htex_r <= ((phase_nxt == PH_TEX) && (stage_nxt == ST_DIGITS)) ? nxt_val : tval_nxt;
      hnorm_r <= (((phase_nxt == PH_NORM) && (stage_nxt == ST_DIGITS)) ||
                  (phase_nxt == PH_DONE)) ? nxt_val : '0;
    end
  end

  assign hand_valid = hvalid_r;
  assign vert_seen  = hseen_r;
  assign vert_raw   = hvert_r;
  assign tex_raw    = htex_r;
  assign norm_raw   = hnorm_r;

endmodule

/* rtl/ofip_resolve.sv */
// ----------------------------------------------------------------------------
// Face corner index resolver
// Maps raw signed indexes onto one-based list positions; output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ofip_resolve #(
  parameter int INDEX_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          hand_valid,
  output logic                          hand_ready,
  input  logic                          vert_seen,
  input  logic signed [INDEX_WIDTH+1:0] vert_raw,
  input  logic signed [INDEX_WIDTH+1:0] tex_raw,
  input  logic signed [INDEX_WIDTH+1:0] norm_raw,
  input  logic [INDEX_WIDTH-1:0]        vertex_count,
  input  logic [INDEX_WIDTH-1:0]        texcoord_count,
  input  logic [INDEX_WIDTH-1:0]        normal_count,
  ofip_corner_if.source                 out_chan
);
  import ofip_pkg::*;

  localparam int W  = INDEX_WIDTH;
  localparam int VW = INDEX_WIDTH + 2;

  // A negative index counts back from the list size; anything outside
  // 0..count resolves to zero.
  function automatic logic [W-1:0] resolve(input logic signed [VW-1:0] v,
                                           input logic [W-1:0] cnt);
    logic signed [VW:0] vx;
    logic signed [VW:0] adj;
    logic               ok;
    vx  = {v[VW-1], v};
    adj = (v < 0) ? (vx + $signed({3'b0, cnt}) + $signed({{VW{1'b0}}, 1'b1})) : vx;
    ok  = !adj[VW] && (adj <= $signed({3'b0, cnt}));
    return ok ? adj[W-1:0] : '0;
  endfunction

  logic         ovalid_r;
  logic         ocv_r;
  logic [W-1:0] ovi_r, oti_r, oni_r;
  logic [W-1:0] vi, ti, ni;
  logic         ok;

  assign vi = resolve(vert_raw, vertex_count);
  assign ti = resolve(tex_raw, texcoord_count);
  assign ni = resolve(norm_raw, normal_count);
  assign ok = vert_seen && (vi != '0);

  assign hand_ready = !ovalid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (hand_ready) begin
      ovalid_r <= hand_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hand_valid && hand_ready) begin
      ocv_r <= ok;
      ovi_r <= ok ? vi : '0;
      oti_r <= ok ? ti : '0;
      oni_r <= ok ? ni : '0;
    end
  end

  assign out_chan.valid          = ovalid_r;
  assign out_chan.corner_valid   = ocv_r;
  assign out_chan.vertex_index   = ovi_r;
  assign out_chan.texcoord_index = oti_r;
  assign out_chan.normal_index   = oni_r;

endmodule

/* verif/obj_face_index_parser_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Face corner parser testbench
// Streams OBJ face-corner tokens into the parser one character per
// transaction. A scanner model in the bench predicts each resolved corner,
// and every corner that leaves the block is compared field by field.
// ----------------------------------------------------------------------------

module obj_face_index_parser_core_tb;
  import ofip_pkg::*;

  localparam int IW = 24;
  // Magnitudes saturate here, always outside every list.
  localparam longint SAT_MAG = (longint'(1) << (IW + 1)) - 1;
  localparam logic [IW-1:0] COUNT_MAX = '1;
  // Two registered stages between the final character and its corner.
  localparam int PIPE_LATENCY = 2;
  localparam int STALL_LIMIT = 4000;
  localparam int ERR_REPORTS = 10;
  localparam int PHASE_CHARS = 265;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic          ok;
    logic [IW-1:0] vtx;
    logic [IW-1:0] tex;
    logic [IW-1:0] nrm;
  } corner_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [IW-1:0] cfg_wdata;

  ofip_char_if char_bus ();
  ofip_corner_if #(.INDEX_WIDTH(IW)) corner_bus ();

  obj_face_index_parser_core #(.INDEX_WIDTH(IW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (char_bus),
    .out_chan (corner_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scanner model. It mirrors the per-token state of the block and the three
  // list sizes, and is advanced once for every accepted character.
  // --------------------------------------------------------------------------
  logic [1:0] field_ph;
  logic [1:0] num_st;
  bit         neg_seen;
  longint     acc_mag;
  longint     vtx_raw;
  longint     tex_raw;
  bit         vtx_had_digits;
  longint     vtx_cnt;
  longint     tex_cnt;
  longint     nrm_cnt;

  corner_t expected_corners[$];
  int      fail_count;
  int      burst_left;
  int      chars_sent;

  function automatic void restart_number();
    num_st   = ST_START;
    neg_seen = 1'b0;
    acc_mag  = 0;
  endfunction

  function automatic void clear_token();
    field_ph       = PH_VERT;
    vtx_raw        = 0;
    tex_raw        = 0;
    vtx_had_digits = 1'b0;
    restart_number();
  endfunction

  function automatic longint signed_acc();
    return neg_seen ? -acc_mag : acc_mag;
  endfunction

  // Negative values count back from the list size; anything still outside
  // 0..count resolves to zero.
  function automatic logic [IW-1:0] resolve_index(input longint raw, input longint cnt);
    longint fixed;
    fixed = raw;
    if (fixed < 0) fixed += cnt + 1;
    if (fixed < 0 || fixed > cnt) return '0;
    return fixed[IW-1:0];
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    logic   is_digit;
    logic   is_space;
    logic   is_sign;
    longint grown;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    if (field_ph == PH_DONE) return;
    case (num_st)
      ST_START, ST_SPACE: begin
        // A slash opening the texture field jumps straight to the normal.
        if (field_ph == PH_TEX && num_st == ST_START && c == CH_SLASH) begin
          field_ph = PH_NORM;
          restart_number();
        end else if (is_space) begin
          num_st = ST_SPACE;
        end else if (is_sign) begin
          num_st   = ST_SIGN;
          neg_seen = (c == CH_MINUS);
        end else if (is_digit) begin
          num_st  = ST_DIGITS;
          acc_mag = longint'(c - CH_ZERO);
        end else begin
          field_ph = PH_DONE;
          restart_number();
        end
      end
      ST_SIGN: begin
        if (is_digit) begin
          num_st  = ST_DIGITS;
          acc_mag = longint'(c - CH_ZERO);
        end else begin
          field_ph = PH_DONE;
          restart_number();
        end
      end
      default: begin
        if (is_digit) begin
          grown   = acc_mag * 10 + longint'(c - CH_ZERO);
          acc_mag = (grown > SAT_MAG) ? SAT_MAG : grown;
        end else if (field_ph == PH_VERT) begin
          vtx_raw        = signed_acc();
          vtx_had_digits = 1'b1;
          field_ph       = (c == CH_SLASH) ? PH_TEX : PH_DONE;
          restart_number();
        end else if (field_ph == PH_TEX) begin
          tex_raw  = signed_acc();
          field_ph = (c == CH_SLASH) ? PH_NORM : PH_DONE;
          restart_number();
        end else begin
          // The normal value stays in the accumulator until the token ends.
          field_ph = PH_DONE;
          num_st   = ST_START;
        end
      end
    endcase
  endfunction

  function automatic corner_t close_token();
    longint        v_raw;
    longint        t_raw;
    longint        n_raw;
    bit            seen;
    logic [IW-1:0] vi;
    corner_t       r;
    if (field_ph == PH_VERT && num_st == ST_DIGITS) begin
      v_raw = signed_acc();
      seen  = 1'b1;
    end else begin
      v_raw = vtx_raw;
      seen  = vtx_had_digits;
    end
    t_raw = (field_ph == PH_TEX && num_st == ST_DIGITS) ? signed_acc() : tex_raw;
    n_raw = ((field_ph == PH_NORM && num_st == ST_DIGITS) || field_ph == PH_DONE)
            ? signed_acc() : 0;
    vi    = resolve_index(v_raw, vtx_cnt);
    r.ok  = seen && (vi != '0);
    // An invalid corner carries zeros in every field.
    r.vtx = r.ok ? vi : '0;
    r.tex = r.ok ? resolve_index(t_raw, tex_cnt) : '0;
    r.nrm = r.ok ? resolve_index(n_raw, nrm_cnt) : '0;
    clear_token();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Character sender. It works in bursts of random length separated by random
  // gaps, and each accepted transaction advances the scanner model.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
      if (gap > 0) begin
        char_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    char_bus.valid     <= 1'b1;
    char_bus.text_char <= c;
    char_bus.token_end <= last;
    do @(posedge clk); while (!char_bus.ready);
    chars_sent++;
    scan_char(c);
    if (last) expected_corners = {expected_corners, close_token()};
  endtask

  task automatic send_token(input byte_q_t tok);
    foreach (tok[i]) send_char(tok[i], i == tok.size() - 1);
  endtask

  task automatic send_text(input string s);
    byte_q_t tok;
    for (int i = 0; i < s.len(); i++) tok = {tok, 8'(s[i])};
    send_token(tok);
  endtask

  // List sizes change only while the block is idle: every corner has come
  // out, and the scanner has had time to settle after the last character.
  task automatic set_counts(input logic [IW-1:0] v, input logic [IW-1:0] t,
                            input logic [IW-1:0] n);
    logic [IW-1:0] vals[3];
    logic [1:0]    regs[3];
    vals = '{v, t, n};
    regs = '{CFG_VERTEX_COUNT, CFG_TEXCOORD_COUNT, CFG_NORMAL_COUNT};
    char_bus.valid <= 1'b0;
    while (expected_corners.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    vtx_cnt = longint'(v);
    tex_cnt = longint'(t);
    nrm_cnt = longint'(n);
  endtask

  // One index number: optional whitespace and sign, then a magnitude that is
  // usually inside the list, sometimes on its edge, zero, or far too large.
  function automatic byte_q_t number_text(input longint cnt);
    byte_q_t q;
    string   digits;
    longint  mag;
    int      pick;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2))
        q = {q, ($urandom_range(0, 1) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4)))};
    end
    pick = $urandom_range(0, 9);
    if (pick == 7) q = {q, CH_PLUS};
    else if (pick >= 8) q = {q, CH_MINUS};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: mag = (cnt > 0) ? longint'($urandom_range(1, 32'(cnt))) : 0;
      5:             mag = cnt + $urandom_range(0, 1);
      6:             mag = 0;
      7:             mag = $urandom_range(0, 32'h1FF_FFFF);
      default:       mag = 64'd1_000_000_000 + longint'($urandom);
    endcase
    if ($urandom_range(0, 15) == 0) q = {q, CH_ZERO};
    digits = $sformatf("%0d", mag);
    for (int i = 0; i < digits.len(); i++) q = {q, 8'(digits[i])};
    return q;
  endfunction

  // Mostly well-formed tokens of every shape; the rest is noise, trailing
  // junk, or a well-formed token with one character broken.
  function automatic byte_q_t random_token();
    byte_q_t tok;
    int      shape;
    bit      has_tex;
    bit      has_nrm;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 6)) tok = {tok, 8'($urandom)};
      return tok;
    end
    tok     = number_text(vtx_cnt);
    shape   = $urandom_range(0, 9);
    has_tex = (shape == 2) || (shape >= 4 && shape <= 7);
    has_nrm = (shape == 3) || (shape >= 4 && shape <= 7);
    if (shape >= 2) tok = {tok, CH_SLASH};
    if (has_tex) tok = {tok, number_text(tex_cnt)};
    if (has_nrm || shape == 9) tok = {tok, CH_SLASH};
    if (has_nrm) tok = {tok, number_text(nrm_cnt)};
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) tok = {tok, 8'($urandom)};
    if ($urandom_range(0, 99) < 8) tok[$urandom_range(0, tok.size() - 1)] = 8'($urandom);
    return tok;
  endfunction

  // --------------------------------------------------------------------------
  // Corner receiver. Ready follows stretches of its own: always ready, coin
  // flips, mostly stalled, and fully stalled. Each corner transaction is
  // compared against the oldest prediction.
  // --------------------------------------------------------------------------
  int stall_mode;
  int stall_left;

  always @(posedge clk) begin : corner_check
    corner_t want;
    corner_t got;
    if (rst_n && corner_bus.valid && corner_bus.ready) begin
      got = '{corner_bus.corner_valid, corner_bus.vertex_index,
              corner_bus.texcoord_index, corner_bus.normal_index};
      if (expected_corners.size() == 0) begin
        fail_count++;
        if (fail_count <= ERR_REPORTS)
          $display("%0t: corner with nothing predicted: ok=%0d v=%0d t=%0d n=%0d",
                   $realtime, got.ok, got.vtx, got.tex, got.nrm);
      end else begin
        want = expected_corners.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= ERR_REPORTS)
            $display("%0t: mismatch exp ok=%0d v=%0d t=%0d n=%0d got ok=%0d v=%0d t=%0d n=%0d",
                     $realtime, want.ok, want.vtx, want.tex, want.nrm,
                     got.ok, got.vtx, got.tex, got.nrm);
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 48);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       corner_bus.ready <= 1'b1;
      1:       corner_bus.ready <= $urandom_range(0, 1);
      2:       corner_bus.ready <= ($urandom_range(0, 3) == 0);
      default: corner_bus.ready <= 1'b0;
    endcase
  end

  // The watchdog ends the run when neither channel moves for too long.
  int quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (char_bus.valid && char_bus.ready) ||
        (corner_bus.valid && corner_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // With all list sizes at zero after reset, no corner can be valid.
  task automatic test_zero_counts();
    send_text("1/1/1");
    send_text("-1");
    send_text("0");
  endtask

  // Every token shape and the parsing corner cases against small lists.
  task automatic test_field_forms();
    byte_q_t nul_tok;
    nul_tok = {8'h33, CH_NUL, 8'h35};
    set_counts(24'd10, 24'd5, 24'd7);
    send_text("3/2/4");
    send_text("3");
    send_text("3/2");
    send_text(" \013\0147//4");
    // Whitespace and signs inside every field, negative texture and normal.
    send_text("\t+3/ -1/\015-2");
    send_text("-10//-7");
    // Minus zero and a vertex past the list are both invalid.
    send_text("-0");
    send_text("11");
    // No vertex digits at all.
    send_text("/5");
    send_text("- 3");
    // A texture field without digits stops the normal from being read.
    send_text("3/x/4");
    send_text("3/");
    send_text("3/-6/8");
    // Text after the fields, and everything after a NUL, is ignored.
    send_text("3x9");
    send_token(nul_tok);
    // Saturated magnitudes fall outside every list.
    send_text("99999999999/1/1");
    send_text("4/99999999999/-99999999999");
  endtask

  // The largest list sizes, with indexes right on and just past the edge.
  task automatic test_extreme_counts();
    set_counts(COUNT_MAX, COUNT_MAX, COUNT_MAX);
    send_text("16777215/16777215/16777215");
    send_text("-16777215//-16777215");
    send_text("16777216/1/1");
    send_text("1/-16777216/16777216");
  endtask

  // Random tokens under several list-size settings, the extremes among them.
  task automatic test_random_tokens();
    int phase_end;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_counts(IW'($urandom_range(1, 40)), IW'($urandom_range(1, 40)),
                      IW'($urandom_range(1, 40)));
        1: set_counts(IW'($urandom_range(1, 40)), '0, '0);
        2: set_counts(COUNT_MAX, COUNT_MAX, COUNT_MAX);
        3: set_counts(IW'($urandom), IW'($urandom), IW'($urandom));
        4: set_counts(24'd1, 24'd1, 24'd1);
        default: set_counts('0, IW'($urandom_range(1, 40)), IW'($urandom_range(1, 40)));
      endcase
      phase_end = chars_sent + PHASE_CHARS;
      while (chars_sent < phase_end) send_token(random_token());
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_VERTEX_COUNT;
    cfg_wdata           <= '0;
    char_bus.valid      <= 1'b0;
    char_bus.text_char  <= '0;
    char_bus.token_end  <= 1'b0;
    burst_left          = 0;
    chars_sent          = 0;
    vtx_cnt             = 0;
    tex_cnt             = 0;
    nrm_cnt             = 0;
    clear_token();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_zero_counts();
    test_field_forms();
    test_extreme_counts();
    test_random_tokens();

    // Drain: wait for every predicted corner, then a little longer so that
    // any extra corner would still be caught.
    char_bus.valid <= 1'b0;
    while (expected_corners.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY * 4) @(posedge clk);
    if (fail_count == 0 && expected_corners.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
